### rtl/clas_pkg.sv
package clas_pkg;

  localparam int unsigned CH_W     = 16;
  localparam int unsigned SLASH_W  = 8;
  localparam int unsigned COUNT_W  = 16;
  localparam int unsigned OUT_DATA_W = 56;
  localparam int unsigned OUT_USER_W = 2;

  localparam logic [SLASH_W-1:0] MAX_SLASH_RUN = 8'd255;

  localparam logic [CH_W-1:0] CH_QUOTE  = 16'h0022;
  localparam logic [CH_W-1:0] CH_BSLASH = 16'h005C;
  localparam logic [CH_W-1:0] CH_SPACE  = 16'h0020;
  localparam logic [CH_W-1:0] CH_TAB    = 16'h0009;
  localparam logic [CH_W-1:0] CH_NUL    = 16'h0000;

  typedef enum logic [1:0] {
    PH_FIRST   = 2'd0,
    PH_BETWEEN = 2'd1,
    PH_ARG     = 2'd2,
    PH_DONE    = 2'd3
  } phase_t;

  typedef struct packed {
    logic [COUNT_W-1:0] char_count;
    logic [COUNT_W-1:0] arg_count;
    logic               line_end;
    logic               arg_end;
    logic               char_valid;
    logic [SLASH_W-1:0] slash_run;
    logic [CH_W-1:0]    out_char;
  } result_t;

endpackage

### rtl/clas_core.sv
module clas_core (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      step_en,
  input  logic [clas_pkg::CH_W-1:0] ch,
  output logic                      emit,
  output clas_pkg::result_t         res
);

  clas_pkg::phase_t                  phase_r, phase_nxt;
  logic                              quoting_r, quoting_nxt;
  logic                              pending_r, pending_nxt;
  logic [clas_pkg::SLASH_W-1:0]      slash_r, slash_nxt;
  logic [clas_pkg::COUNT_W-1:0]      args_r, args_nxt;
  logic [clas_pkg::COUNT_W-1:0]      units_r, units_nxt;

  logic                              do_arg;
  logic                              is_blank;
  logic [clas_pkg::SLASH_W-2:0]      half;

  assign is_blank = (ch == clas_pkg::CH_SPACE) || (ch == clas_pkg::CH_TAB);
  assign half     = slash_r[clas_pkg::SLASH_W-1:1];

  always_comb begin
    phase_nxt   = phase_r;
    quoting_nxt = quoting_r;
    pending_nxt = pending_r;
    slash_nxt   = slash_r;
    args_nxt    = args_r;
    units_nxt   = units_r;
    do_arg      = 1'b0;
    emit        = 1'b0;
    res         = '0;

    unique case (phase_r)
      clas_pkg::PH_FIRST: begin
        if (ch == clas_pkg::CH_QUOTE) begin
          quoting_nxt = !quoting_r;
        end else begin
          units_nxt = units_r + 1'b1;
          emit      = 1'b1;
          if (ch == clas_pkg::CH_NUL) begin
            phase_nxt    = clas_pkg::PH_DONE;
            res.arg_end  = 1'b1;
            res.line_end = 1'b1;
          end else if (!quoting_r && is_blank) begin
            phase_nxt   = clas_pkg::PH_BETWEEN;
            quoting_nxt = 1'b0;
            res.arg_end = 1'b1;
          end else begin
            res.out_char   = ch;
            res.char_valid = 1'b1;
          end
        end
      end
      clas_pkg::PH_BETWEEN: begin
        if (is_blank) begin
          emit = 1'b0;
        end else if (ch == clas_pkg::CH_NUL) begin
          phase_nxt    = clas_pkg::PH_DONE;
          emit         = 1'b1;
          res.line_end = 1'b1;
        end else begin
          args_nxt    = args_r + 1'b1;
          phase_nxt   = clas_pkg::PH_ARG;
          quoting_nxt = 1'b0;
          pending_nxt = 1'b0;
          slash_nxt   = '0;
          do_arg      = 1'b1;
        end
      end
      clas_pkg::PH_ARG: begin
        if (pending_r) begin
          pending_nxt = 1'b0;
          if (ch == clas_pkg::CH_QUOTE) begin
            // doubled quote inside quotes
            units_nxt      = units_r + 1'b1;
            emit           = 1'b1;
            res.out_char   = clas_pkg::CH_QUOTE;
            res.char_valid = 1'b1;
          end else begin
            quoting_nxt = 1'b0;
            do_arg      = 1'b1;
          end
        end else begin
          do_arg = 1'b1;
        end
      end
      clas_pkg::PH_DONE: begin
        emit = 1'b0;
      end
      default: begin
        emit = 1'b0;
      end
    endcase

    if (do_arg) begin
      if (ch == clas_pkg::CH_BSLASH) begin
        if (slash_nxt < clas_pkg::MAX_SLASH_RUN) begin
          slash_nxt = slash_nxt + 1'b1;
        end
      end else begin
        slash_nxt = '0;
        if (ch == clas_pkg::CH_QUOTE) begin
          if (!slash_r[0]) begin
            // even run: toggle, or arm the doubled-quote check
            if (quoting_nxt) begin
              pending_nxt = 1'b1;
            end else begin
              quoting_nxt = 1'b1;
            end
            units_nxt     = units_nxt + {{(clas_pkg::COUNT_W-clas_pkg::SLASH_W+1){1'b0}}, half};
            emit          = (half != '0);
            res.slash_run = {1'b0, half};
          end else begin
            units_nxt      = units_nxt + {{(clas_pkg::COUNT_W-clas_pkg::SLASH_W+1){1'b0}}, half}
                             + 1'b1;
            emit           = 1'b1;
            res.out_char   = clas_pkg::CH_QUOTE;
            res.char_valid = 1'b1;
            res.slash_run  = {1'b0, half};
          end
        end else begin
          units_nxt     = units_nxt + {{(clas_pkg::COUNT_W-clas_pkg::SLASH_W){1'b0}}, slash_r}
                          + 1'b1;
          emit          = 1'b1;
          res.slash_run = slash_r;
          if (ch == clas_pkg::CH_NUL) begin
            phase_nxt    = clas_pkg::PH_DONE;
            res.arg_end  = 1'b1;
            res.line_end = 1'b1;
          end else if (!quoting_nxt && is_blank) begin
            phase_nxt   = clas_pkg::PH_BETWEEN;
            res.arg_end = 1'b1;
          end else begin
            res.out_char   = ch;
            res.char_valid = 1'b1;
          end
        end
      end
    end

    res.arg_count  = args_nxt;
    res.char_count = units_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= clas_pkg::PH_FIRST;
      quoting_r <= 1'b0;
      pending_r <= 1'b0;
      slash_r   <= '0;
      args_r    <= {{(clas_pkg::COUNT_W-1){1'b0}}, 1'b1};
      units_r   <= '0;
    end else if (step_en) begin
      phase_r   <= phase_nxt;
      quoting_r <= quoting_nxt;
      pending_r <= pending_nxt;
      slash_r   <= slash_nxt;
      args_r    <= args_nxt;
      units_r   <= units_nxt;
    end
  end

endmodule

### rtl/command_line_argument_splitter_top.sv
// command line argument splitter, windows argv rules
// in channel: one utf-16 code unit per request on in_tdata, a zero unit ends the line
// out channel: zero or one result per input unit; tdata carries the copied
// character, the count of backslashes to store before it, and the running
// argument and code unit counts; tuser flags a copied character and an
// argument end; tlast marks the end of the whole line
// path: an accepted unit passes the input register, then the parser logic into
// the result register, which drives the out port
// throughput: one unit per cycle; the parser state update is a single
// registered pass, so units stream back to back while the out side takes
// results
// stall: when out_tready is low the result register holds and the input
// register fills; in_tready falls only once both are occupied
// reset: synchronous, active low; clears the parser back to the program-name
// token with one argument counted and zero code units, drops pending requests
// units after the line end produce nothing until the next reset
module command_line_argument_splitter_top (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [clas_pkg::CH_W-1:0]           in_tdata,   // [15:0] ch
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // [15:0] out_char, [23:16] slash_run, [39:24] arg_count, [55:40] char_count
  output logic [clas_pkg::OUT_DATA_W-1:0]     out_tdata,
  output logic [clas_pkg::OUT_USER_W-1:0]     out_tuser,  // [0] char_valid, [1] arg_end
  output logic                                out_tlast   // line_end
);

  logic                        in_v_r, in_v_nxt;
  logic [clas_pkg::CH_W-1:0]   in_ch_r;
  logic                        out_v_r, out_v_nxt;
  clas_pkg::result_t           out_res_r;
  logic                        advance;
  logic                        emit;
  clas_pkg::result_t           res;

  assign advance   = in_v_r && (!out_v_r || out_tready);
  assign in_tready = !in_v_r || advance;

  clas_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (advance),
    .ch      (in_ch_r),
    .emit    (emit),
    .res     (res)
  );

  always_comb begin
    in_v_nxt = in_v_r;
    if (in_tvalid && in_tready) begin
      in_v_nxt = 1'b1;
    end else if (advance) begin
      in_v_nxt = 1'b0;
    end
    out_v_nxt = out_v_r;
    if (advance) begin
      out_v_nxt = emit;
    end else if (out_tready) begin
      out_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      in_v_r  <= in_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_ch_r <= in_tdata;
    end
    if (advance) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {out_res_r.char_count, out_res_r.arg_count,
                       out_res_r.slash_run, out_res_r.out_char};
  assign out_tuser  = {out_res_r.arg_end, out_res_r.char_valid};
  assign out_tlast  = out_res_r.line_end;

endmodule

### tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned CYCLE_LIMIT = 2_000_000;
  localparam int unsigned BULK_ARGS   = 8;

  typedef struct packed {
    logic [clas_pkg::CH_W-1:0] ch;
    logic                      typed;    // expectation written in the row
    logic                      has_res;
    clas_pkg::result_t         res;
  } unit_row_t;

  logic                            clk        = 1'b0;
  logic                            rst_n      = 1'b0;
  logic                            in_tvalid  = 1'b0;
  logic [clas_pkg::CH_W-1:0]       in_tdata   = '0;
  logic                            out_tready = 1'b0;
  logic                            in_tready;
  logic                            out_tvalid;
  logic [clas_pkg::OUT_DATA_W-1:0] out_tdata;
  logic [clas_pkg::OUT_USER_W-1:0] out_tuser;
  logic                            out_tlast;

  // argv splitter state as seen by the expectation side
  clas_pkg::phase_t             pr_phase;
  bit                           pr_quoting;
  bit                           pr_pending;
  logic [clas_pkg::SLASH_W-1:0] pr_slashes;
  logic [clas_pkg::COUNT_W-1:0] pr_args;
  logic [clas_pkg::COUNT_W-1:0] pr_units;

  clas_pkg::result_t owed_pieces[$];
  unit_row_t         dir_rows[$];
  int                idle_pct   = 0;
  int                stall_pct  = 0;
  int                n_accepted = 0;
  int                mismatches = 0;

  command_line_argument_splitter_top u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always #5 clk = ~clk;

  function automatic clas_pkg::result_t make_result(logic [clas_pkg::CH_W-1:0] c,
                                                    logic [clas_pkg::SLASH_W-1:0] sl,
                                                    bit v, bit ae, bit le,
                                                    logic [clas_pkg::COUNT_W-1:0] ac,
                                                    logic [clas_pkg::COUNT_W-1:0] uc);
    clas_pkg::result_t r;
    r.out_char   = v ? c : '0;
    r.slash_run  = sl;
    r.char_valid = v;
    r.arg_end    = ae;
    r.line_end   = le;
    r.arg_count  = ac;
    r.char_count = uc;
    return r;
  endfunction

  function automatic bit is_blank(logic [clas_pkg::CH_W-1:0] c);
    return c == clas_pkg::CH_SPACE || c == clas_pkg::CH_TAB;
  endfunction

  // one code unit inside an argument after the program name
  function automatic bit arg_step(input logic [clas_pkg::CH_W-1:0] c,
                                  output clas_pkg::result_t r);
    logic [clas_pkg::SLASH_W-1:0] n;
    logic [clas_pkg::SLASH_W-1:0] half;
    r = '0;
    if (c == clas_pkg::CH_BSLASH) begin
      if (pr_slashes < clas_pkg::MAX_SLASH_RUN) pr_slashes++;
      return 1'b0;
    end
    n = pr_slashes;
    pr_slashes = '0;
    half = n >> 1;
    if (c == clas_pkg::CH_QUOTE) begin
      if (!n[0]) begin
        if (pr_quoting) pr_pending = 1'b1;
        else pr_quoting = 1'b1;
        pr_units = pr_units + 16'(half);
        if (half == '0) return 1'b0;
        r = make_result(clas_pkg::CH_NUL, half, 1'b0, 1'b0, 1'b0, pr_args, pr_units);
        return 1'b1;
      end
      pr_units = pr_units + 16'(half) + 16'd1;
      r = make_result(clas_pkg::CH_QUOTE, half, 1'b1, 1'b0, 1'b0, pr_args, pr_units);
      return 1'b1;
    end
    pr_units = pr_units + 16'(n) + 16'd1;
    if (c == clas_pkg::CH_NUL) begin
      pr_phase = clas_pkg::PH_DONE;
      r = make_result(clas_pkg::CH_NUL, n, 1'b0, 1'b1, 1'b1, pr_args, pr_units);
    end else if (!pr_quoting && is_blank(c)) begin
      pr_phase = clas_pkg::PH_BETWEEN;
      r = make_result(clas_pkg::CH_NUL, n, 1'b0, 1'b1, 1'b0, pr_args, pr_units);
    end else begin
      r = make_result(c, n, 1'b1, 1'b0, 1'b0, pr_args, pr_units);
    end
    return 1'b1;
  endfunction

  function automatic bit parse_unit(input logic [clas_pkg::CH_W-1:0] c,
                                    output clas_pkg::result_t r);
    r = '0;
    case (pr_phase)
      clas_pkg::PH_FIRST: begin
        // program name: quotes toggle, backslashes are plain
        if (c == clas_pkg::CH_QUOTE) begin
          pr_quoting = !pr_quoting;
          return 1'b0;
        end
        pr_units = pr_units + 16'd1;
        if (c == clas_pkg::CH_NUL) begin
          pr_phase = clas_pkg::PH_DONE;
          r = make_result(clas_pkg::CH_NUL, '0, 1'b0, 1'b1, 1'b1, pr_args, pr_units);
        end else if (!pr_quoting && is_blank(c)) begin
          pr_phase = clas_pkg::PH_BETWEEN;
          pr_quoting = 1'b0;
          r = make_result(clas_pkg::CH_NUL, '0, 1'b0, 1'b1, 1'b0, pr_args, pr_units);
        end else begin
          r = make_result(c, '0, 1'b1, 1'b0, 1'b0, pr_args, pr_units);
        end
        return 1'b1;
      end
      clas_pkg::PH_BETWEEN: begin
        if (is_blank(c)) return 1'b0;
        if (c == clas_pkg::CH_NUL) begin
          pr_phase = clas_pkg::PH_DONE;
          r = make_result(clas_pkg::CH_NUL, '0, 1'b0, 1'b0, 1'b1, pr_args, pr_units);
          return 1'b1;
        end
        pr_args = pr_args + 16'd1;
        pr_phase = clas_pkg::PH_ARG;
        pr_quoting = 1'b0;
        pr_pending = 1'b0;
        pr_slashes = '0;
        return arg_step(c, r);
      end
      clas_pkg::PH_ARG: begin
        if (pr_pending) begin
          pr_pending = 1'b0;
          // doubled quote inside quotes
          if (c == clas_pkg::CH_QUOTE) begin
            pr_units = pr_units + 16'd1;
            r = make_result(clas_pkg::CH_QUOTE, '0, 1'b1, 1'b0, 1'b0, pr_args, pr_units);
            return 1'b1;
          end
          pr_quoting = 1'b0;
        end
        return arg_step(c, r);
      end
      default: return 1'b0;
    endcase
  endfunction

  task automatic drive_unit(input logic [clas_pkg::CH_W-1:0] c);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= c;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    n_accepted++;
  endtask

  task automatic push_unit(input logic [clas_pkg::CH_W-1:0] c);
    clas_pkg::result_t r;
    drive_unit(c);
    if (parse_unit(c, r)) owed_pieces.push_back(r);
  endtask

  task automatic send_piece();
    logic [clas_pkg::CH_W-1:0] specials[4] = '{clas_pkg::CH_QUOTE, clas_pkg::CH_BSLASH,
                                               clas_pkg::CH_SPACE, clas_pkg::CH_TAB};
    int kind;
    kind = $urandom_range(0, 11);
    if ($urandom_range(0, 299) == 0) begin
      // long run that can saturate the counter
      repeat ($urandom_range(250, 300)) push_unit(clas_pkg::CH_BSLASH);
      push_unit(clas_pkg::CH_QUOTE);
    end else begin
      case (kind)
        0, 1, 2: push_unit(16'($urandom_range(1, 16'hFFFF)));
        3, 4: push_unit(16'($urandom_range(16'h61, 16'h7A)));
        5, 6: begin
          repeat ($urandom_range(1, 4)) push_unit(clas_pkg::CH_BSLASH);
          push_unit(kind == 5 ? clas_pkg::CH_QUOTE : 16'($urandom_range(16'h61, 16'h7A)));
        end
        7: push_unit(clas_pkg::CH_QUOTE);
        8: begin
          push_unit(clas_pkg::CH_QUOTE);
          push_unit(clas_pkg::CH_QUOTE);
        end
        9, 10: repeat ($urandom_range(1, 2))
          push_unit($urandom_range(0, 1) ? clas_pkg::CH_SPACE : clas_pkg::CH_TAB);
        default: push_unit(specials[2'($urandom_range(0, 3))]);
      endcase
    end
  endtask

  function automatic void cmp_field(string fname, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t %s expected %h actual %h", $time, fname, want, got);
    end
  endfunction

  task automatic check_piece();
    clas_pkg::result_t want;
    if (owed_pieces.size() == 0) begin
      mismatches++;
      $display("%0t unexpected result expected none actual %h %h %b", $time, out_tdata,
               out_tuser, out_tlast);
      return;
    end
    want = owed_pieces.pop_front();
    cmp_field("out_char", want.out_char, out_tdata[15:0]);
    cmp_field("slash_run", 16'(want.slash_run), 16'(out_tdata[23:16]));
    cmp_field("arg_count", want.arg_count, out_tdata[39:24]);
    cmp_field("char_count", want.char_count, out_tdata[55:40]);
    cmp_field("char_valid", 16'(want.char_valid), 16'(out_tuser[0]));
    cmp_field("arg_end", 16'(want.arg_end), 16'(out_tuser[1]));
    cmp_field("line_end", 16'(want.line_end), 16'(out_tlast));
  endtask

  // result side: checks, random stalls and one long hold-off
  initial begin
    int hold_left;
    bit held;
    hold_left = 0;
    held = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n) begin
        if (out_tvalid && out_tready) check_piece();
        if (!held && n_accepted >= 60) begin
          held = 1'b1;
          hold_left = 400;
        end
        if (hold_left > 0) begin
          hold_left--;
          out_tready <= 1'b0;
        end else begin
          out_tready <= ($urandom_range(0, 99) >= stall_pct);
        end
      end
    end
  end

  initial begin
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("tb_top NOT OK");
    $finish;
  end

  initial begin
    clas_pkg::result_t r;
    bit                has;
    int                base;

    pr_phase   = clas_pkg::PH_FIRST;
    pr_quoting = 1'b0;
    pr_pending = 1'b0;
    pr_slashes = '0;
    pr_args    = 16'd1;
    pr_units   = '0;

    // program name
    dir_rows.push_back('{clas_pkg::CH_QUOTE, 1'b1, 1'b0, '0});
    dir_rows.push_back('{16'h0041, 1'b1, 1'b1,
                         make_result(16'h0041, 8'd0, 1'b1, 1'b0, 1'b0, 16'd1, 16'd1)});
    dir_rows.push_back('{clas_pkg::CH_SPACE, 1'b1, 1'b1,
                         make_result(clas_pkg::CH_SPACE, 8'd0, 1'b1, 1'b0, 1'b0,
                                     16'd1, 16'd2)});
    dir_rows.push_back('{clas_pkg::CH_BSLASH, 1'b1, 1'b1,
                         make_result(clas_pkg::CH_BSLASH, 8'd0, 1'b1, 1'b0, 1'b0,
                                     16'd1, 16'd3)});
    dir_rows.push_back('{clas_pkg::CH_QUOTE, 1'b1, 1'b0, '0});
    dir_rows.push_back('{16'hFFFF, 1'b1, 1'b1,
                         make_result(16'hFFFF, 8'd0, 1'b1, 1'b0, 1'b0, 16'd1, 16'd4)});
    dir_rows.push_back('{clas_pkg::CH_TAB, 1'b1, 1'b1,
                         make_result(clas_pkg::CH_NUL, 8'd0, 1'b0, 1'b1, 1'b0,
                                     16'd1, 16'd5)});
    // leading blanks skipped
    dir_rows.push_back('{clas_pkg::CH_SPACE, 1'b1, 1'b0, '0});
    dir_rows.push_back('{clas_pkg::CH_TAB, 1'b1, 1'b0, '0});
    // even run opens quotes, doubled quote, even run before closing quote
    dir_rows.push_back('{16'h0001, 1'b0, 1'b0, '0});
    dir_rows.push_back('{clas_pkg::CH_BSLASH, 1'b0, 1'b0, '0});
    dir_rows.push_back('{clas_pkg::CH_BSLASH, 1'b0, 1'b0, '0});
    dir_rows.push_back('{clas_pkg::CH_QUOTE, 1'b0, 1'b0, '0});
    dir_rows.push_back('{16'h8000, 1'b0, 1'b0, '0});
    dir_rows.push_back('{clas_pkg::CH_QUOTE, 1'b0, 1'b0, '0});
    dir_rows.push_back('{clas_pkg::CH_QUOTE, 1'b0, 1'b0, '0});
    dir_rows.push_back('{clas_pkg::CH_BSLASH, 1'b0, 1'b0, '0});
    dir_rows.push_back('{clas_pkg::CH_BSLASH, 1'b0, 1'b0, '0});
    dir_rows.push_back('{clas_pkg::CH_QUOTE, 1'b0, 1'b0, '0});
    // pending quote followed by a plain unit
    dir_rows.push_back('{16'h007A, 1'b0, 1'b0, '0});
    dir_rows.push_back('{clas_pkg::CH_SPACE, 1'b0, 1'b0, '0});
    // odd run gives a literal quote, lone backslash copied
    dir_rows.push_back('{clas_pkg::CH_BSLASH, 1'b0, 1'b0, '0});
    dir_rows.push_back('{clas_pkg::CH_BSLASH, 1'b0, 1'b0, '0});
    dir_rows.push_back('{clas_pkg::CH_BSLASH, 1'b0, 1'b0, '0});
    dir_rows.push_back('{clas_pkg::CH_QUOTE, 1'b0, 1'b0, '0});
    dir_rows.push_back('{clas_pkg::CH_BSLASH, 1'b0, 1'b0, '0});
    dir_rows.push_back('{16'h0062, 1'b0, 1'b0, '0});

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) begin
      drive_unit(dir_rows[i].ch);
      has = parse_unit(dir_rows[i].ch, r);
      if (dir_rows[i].typed) begin
        has = dir_rows[i].has_res;
        r = dir_rows[i].res;
      end
      if (has) owed_pieces.push_back(r);
    end

    // no idling; the long hold-off on the result side falls in here
    base = n_accepted;
    while (n_accepted < base + 45) send_piece();

    // saturating backslash runs before a quote and before a plain unit
    repeat ($urandom_range(256, 270)) push_unit(clas_pkg::CH_BSLASH);
    push_unit(clas_pkg::CH_QUOTE);
    repeat (258) push_unit(clas_pkg::CH_BSLASH);
    push_unit(16'($urandom_range(16'h61, 16'h7A)));

    // leave quotes, then a few short arguments
    while (pr_phase == clas_pkg::PH_ARG && (pr_quoting || pr_pending))
      push_unit(pr_pending ? 16'h0078 : clas_pkg::CH_QUOTE);
    repeat (BULK_ARGS) begin
      push_unit($urandom_range(0, 1) ? clas_pkg::CH_SPACE : clas_pkg::CH_TAB);
      push_unit(16'($urandom_range(16'h61, 16'h7A)));
    end

    idle_pct = 60;
    base = n_accepted;
    while (n_accepted < base + 45) send_piece();

    idle_pct = 0;
    stall_pct = 60;
    base = n_accepted;
    while (n_accepted < base + 45) send_piece();

    idle_pct = 32;
    stall_pct = 32;
    base = n_accepted;
    while (n_accepted < base + 45) send_piece();

    // end of line, then units that must be dropped
    if ($urandom_range(0, 1)) push_unit(clas_pkg::CH_SPACE);
    push_unit(clas_pkg::CH_NUL);
    repeat (4) push_unit(16'($urandom));
    in_tvalid <= 1'b0;

    while (owed_pieces.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
